### rtl/dvru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvru_pkg
// Shared constants for the distance-vector route update core.
// ----------------------------------------------------------------------------
package dvru_pkg;

	localparam int DEF_MAX_ROUTES         = 16;
	localparam int DEF_MAX_NEIGHBORS      = 16;
	localparam int DEF_MAX_VECTOR_ENTRIES = 16;

	localparam logic [15:0] NODE_LOW  = 16'd1025;
	localparam logic [15:0] NODE_HIGH = 16'd65535;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_NODE  = 3'd1;
	localparam logic [2:0] ST_UNKNOWN   = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_SELF      = 3'd4;
	localparam logic [2:0] ST_DUPLICATE = 3'd5;

	localparam logic KIND_ADD    = 1'b0;
	localparam logic KIND_VECTOR = 1'b1;

endpackage

### rtl/distance_vector_route_update_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_vector_route_update_core
// Bellman-Ford route table update with neighbor table and vector staging.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// config    in         cfg_we                    cfg_data (self_id)
// command   in         start & !busy             kind peer_id node_id distance last
// result    out        done (one cycle)          status route_* table_changed
//                                                send_table end_of_run
//
// A non-last vector entry is staged in the accept cycle and busy stays low.
// Other items walk the tables held in RAM, one entry at a time: address,
// then registered read data. An add searches the neighbors, then the routes;
// a merge searches the neighbors, then the routes for each staged entry, and
// emits the table when it changed or on the first run. Reset clears counts and
// flags and sets self_id to NODE_LOW; the tables need no clearing. Results cannot be stalled.
// ----------------------------------------------------------------------------
module distance_vector_route_update_core #(
	parameter int MAX_ROUTES         = dvru_pkg::DEF_MAX_ROUTES,
	parameter int MAX_NEIGHBORS      = dvru_pkg::DEF_MAX_NEIGHBORS,
	parameter int MAX_VECTOR_ENTRIES = dvru_pkg::DEF_MAX_VECTOR_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [15:0] peer_id,
	input  logic [15:0] node_id,
	input  logic [15:0] distance,
	input  logic        last,
	output logic        done,
	output logic [2:0]  status,
	output logic [15:0] route_node,
	output logic [15:0] route_distance,
	output logic [15:0] route_next_hop,
	output logic        table_changed,
	output logic        send_table,
	output logic        end_of_run
);
	import dvru_pkg::*;

	localparam int RAW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
	localparam int NAW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int SAW = (MAX_VECTOR_ENTRIES > 1) ? $clog2(MAX_VECTOR_ENTRIES) : 1;
	localparam int RCW = $clog2(MAX_ROUTES + 1);
	localparam int NCW = $clog2(MAX_NEIGHBORS + 1);
	localparam int SCW = $clog2(MAX_VECTOR_ENTRIES + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_NSRCH  = 4'd1;
	localparam logic [3:0] S_NWAIT  = 4'd2;
	localparam logic [3:0] S_RSRCH  = 4'd3;
	localparam logic [3:0] S_RWAIT  = 4'd4;
	localparam logic [3:0] S_APPLY  = 4'd5;
	localparam logic [3:0] S_MREAD  = 4'd6;
	localparam logic [3:0] S_MWAIT  = 4'd7;
	localparam logic [3:0] S_FINISH = 4'd8;
	localparam logic [3:0] S_EREAD  = 4'd9;
	localparam logic [3:0] S_EWAIT  = 4'd10;

	logic [3:0]     state_q;
	logic [15:0]    self_q;
	logic           kind_q;
	logic [15:0]    peer_q, target_q, dist_q, ncost_q, rdist_q;
	logic [RCW-1:0] rcount_q, ridx_q;
	logic [RAW-1:0] rhit_q;
	logic           rfound_q;
	logic [NCW-1:0] ncount_q, nidx_q;
	logic [SCW-1:0] scount_q, cnt_q, midx_q;
	logic           sbad_q, first_q, changed_q;
	logic [2:0]     st_q;

	logic           done_q;
	logic [2:0]     status_q;
	logic [15:0]    rnode_q, rdist_out_q, rhop_q;
	logic           chg_q, snd_q, eor_q;

	logic           rt_we, nb_we, sg_we;
	logic [RAW-1:0] rt_waddr;
	logic [47:0]    rt_wdata, rt_rdata;
	logic [31:0]    nb_rdata, sg_rdata;
	logic           accept, node_good, peer_good, rfull, closer;
	logic [16:0]    sum;

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign node_good  = (node_id >= NODE_LOW) && (node_id <= NODE_HIGH);
	assign peer_good  = (peer_id >= NODE_LOW) && (peer_id <= NODE_HIGH);
	assign rfull      = (rcount_q >= RCW'(MAX_ROUTES));
	assign closer     = (dist_q < rdist_q);
	assign sum        = {1'b0, sg_rdata[15:0]} + {1'b0, ncost_q};
	assign sg_we      = accept && (kind == KIND_VECTOR) && node_good
	                    && (scount_q < SCW'(MAX_VECTOR_ENTRIES));
	assign rt_wdata   = {target_q, dist_q, peer_q};

	always_comb begin
		rt_we    = 1'b0;
		nb_we    = 1'b0;
		rt_waddr = rhit_q;
		if (state_q == S_APPLY) begin
			if (kind_q == KIND_ADD) begin
				if (rfound_q || !rfull) begin
					nb_we = 1'b1;
					if (rfound_q) begin
						rt_we = closer;
					end else begin
						rt_we    = 1'b1;
						rt_waddr = rcount_q[RAW-1:0];
					end
				end
			end else begin
				if (rfound_q) begin
					rt_we = closer;
				end else if (!rfull) begin
					rt_we    = 1'b1;
					rt_waddr = rcount_q[RAW-1:0];
				end
			end
		end
	end

	dvru_ram #(.WIDTH(48), .DEPTH(MAX_ROUTES), .AW(RAW)) u_route_ram (
		.clk   (clk),
		.we    (rt_we),
		.waddr (rt_waddr),
		.wdata (rt_wdata),
		.raddr (ridx_q[RAW-1:0]),
		.rdata (rt_rdata)
	);

	dvru_ram #(.WIDTH(32), .DEPTH(MAX_NEIGHBORS), .AW(NAW)) u_neighbor_ram (
		.clk   (clk),
		.we    (nb_we),
		.waddr (ncount_q[NAW-1:0]),
		.wdata ({peer_q, dist_q}),
		.raddr (nidx_q[NAW-1:0]),
		.rdata (nb_rdata)
	);

	dvru_ram #(.WIDTH(32), .DEPTH(MAX_VECTOR_ENTRIES), .AW(SAW)) u_stage_ram (
		.clk   (clk),
		.we    (sg_we),
		.waddr (scount_q[SAW-1:0]),
		.wdata ({node_id, distance}),
		.raddr (midx_q[SAW-1:0]),
		.rdata (sg_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			self_q    <= NODE_LOW;
			rcount_q  <= '0;
			ncount_q  <= '0;
			scount_q  <= '0;
			sbad_q    <= 1'b0;
			first_q   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				self_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q    <= kind;
						peer_q    <= peer_id;
						target_q  <= peer_id;
						dist_q    <= distance;
						nidx_q    <= '0;
						ridx_q    <= '0;
						midx_q    <= '0;
						st_q      <= ST_OK;
						changed_q <= 1'b0;
						rnode_q     <= '0;
						rdist_out_q <= '0;
						rhop_q      <= '0;
						chg_q       <= 1'b0;
						snd_q       <= 1'b0;
						eor_q       <= 1'b1;
						if (kind == KIND_ADD) begin
							if (!peer_good) begin
								done_q   <= 1'b1;
								status_q <= ST_BAD_NODE;
							end else if (peer_id == self_q) begin
								done_q   <= 1'b1;
								status_q <= ST_SELF;
							end else begin
								state_q <= S_NSRCH;
							end
						end else if (last) begin
							// The vector closes here: clear staging for the next one.
							scount_q <= '0;
							sbad_q   <= 1'b0;
							cnt_q    <= sg_we ? scount_q + 1'b1 : scount_q;
							if (sbad_q || !sg_we) begin
								done_q   <= 1'b1;
								status_q <= ST_BAD_NODE;
							end else begin
								state_q <= S_NSRCH;
							end
						end else begin
							if (sg_we) begin
								scount_q <= scount_q + 1'b1;
							end else begin
								sbad_q <= 1'b1;
							end
						end
					end
				end
				S_NSRCH: begin
					if (nidx_q < ncount_q) begin
						state_q <= S_NWAIT;
					end else if (kind_q == KIND_VECTOR) begin
						done_q   <= 1'b1;
						status_q <= ST_UNKNOWN;
						state_q  <= S_IDLE;
					end else if (ncount_q >= NCW'(MAX_NEIGHBORS)) begin
						done_q   <= 1'b1;
						status_q <= ST_FULL;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_RSRCH;
					end
				end
				S_NWAIT: begin
					if (nb_rdata[31:16] == peer_q) begin
						if (kind_q == KIND_ADD) begin
							done_q   <= 1'b1;
							status_q <= ST_DUPLICATE;
							state_q  <= S_IDLE;
						end else begin
							ncost_q <= nb_rdata[15:0];
							state_q <= S_MREAD;
						end
					end else begin
						nidx_q  <= nidx_q + 1'b1;
						state_q <= S_NSRCH;
					end
				end
				S_RSRCH: begin
					if (ridx_q < rcount_q) begin
						state_q <= S_RWAIT;
					end else begin
						rfound_q <= 1'b0;
						state_q  <= S_APPLY;
					end
				end
				S_RWAIT: begin
					if (rt_rdata[47:32] == target_q) begin
						rfound_q <= 1'b1;
						rhit_q   <= ridx_q[RAW-1:0];
						rdist_q  <= rt_rdata[31:16];
						state_q  <= S_APPLY;
					end else begin
						ridx_q  <= ridx_q + 1'b1;
						state_q <= S_RSRCH;
					end
				end
				S_APPLY: begin
					if (kind_q == KIND_ADD) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (rfound_q || !rfull) begin
							status_q <= ST_OK;
							ncount_q <= ncount_q + 1'b1;
							if (!rfound_q) begin
								rcount_q <= rcount_q + 1'b1;
							end
						end else begin
							status_q <= ST_FULL;
						end
					end else begin
						if (rfound_q) begin
							if (closer) begin
								changed_q <= 1'b1;
							end
						end else if (!rfull) begin
							rcount_q  <= rcount_q + 1'b1;
							changed_q <= 1'b1;
						end else begin
							st_q <= ST_FULL;
						end
						midx_q  <= midx_q + 1'b1;
						state_q <= S_MREAD;
					end
				end
				S_MREAD: begin
					state_q <= (midx_q < cnt_q) ? S_MWAIT : S_FINISH;
				end
				S_MWAIT: begin
					if (sg_rdata[31:16] == self_q) begin
						midx_q  <= midx_q + 1'b1;
						state_q <= S_MREAD;
					end else begin
						target_q <= sg_rdata[31:16];
						dist_q   <= sum[16] ? 16'hFFFF : sum[15:0];
						ridx_q   <= '0;
						state_q  <= S_RSRCH;
					end
				end
				S_FINISH: begin
					status_q <= st_q;
					if (changed_q || !first_q) begin
						first_q <= 1'b1;
						if (rcount_q == '0) begin
							done_q  <= 1'b1;
							chg_q   <= changed_q;
							snd_q   <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							ridx_q  <= '0;
							state_q <= S_EREAD;
						end
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_EREAD: begin
					state_q <= S_EWAIT;
				end
				S_EWAIT: begin
					done_q      <= 1'b1;
					rnode_q     <= rt_rdata[47:32];
					rdist_out_q <= rt_rdata[31:16];
					rhop_q      <= rt_rdata[15:0];
					chg_q       <= changed_q;
					snd_q       <= 1'b1;
					eor_q       <= (ridx_q + 1'b1 == rcount_q);
					ridx_q      <= ridx_q + 1'b1;
					state_q     <= (ridx_q + 1'b1 == rcount_q) ? S_IDLE : S_EREAD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign route_node     = rnode_q;
	assign route_distance = rdist_out_q;
	assign route_next_hop = rhop_q;
	assign table_changed  = chg_q;
	assign send_table     = snd_q;
	assign end_of_run     = eor_q;

endmodule

### rtl/dvru_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvru_ram
// Generic RAM: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dvru_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
